// File: rtl/core/rclp_pkg.sv
// rclp_pkg: constants, phase encoding and control types of the RC link frame parser.
// Used by rclp_crc8, rclp_unpack and rc_link_frame_parser; depends on nothing.
`timescale 1ns / 1ps

package rclp_pkg;

	localparam int MAX_FRAME_BYTES = 64;
	localparam int CNT_W           = $clog2(MAX_FRAME_BYTES + 1);
	localparam int LEN_CMP_W       = 9;

	localparam logic [7:0] SYNC_BYTE     = 8'hC8;
	localparam logic [7:0] TYPE_CHANNELS = 8'h16;
	localparam logic [7:0] CRC_POLY      = 8'hD5;
	localparam int         MIN_FRAME     = 4;

	localparam int CHAN_BITS    = 11;
	localparam int NUM_CHANNELS = 16;
	localparam int CH_TOTAL     = NUM_CHANNELS * CHAN_BITS;
	localparam int CH_BYTES     = (CH_TOTAL + 7) / 8;
	localparam int CH_FIRST     = 3;
	localparam int CH_LAST      = CH_FIRST + CH_BYTES - 1;
	localparam int IDX_W        = $clog2(CH_BYTES);
	localparam int CHI_W        = $clog2(NUM_CHANNELS);
	localparam int BITC_W       = $clog2(CHAN_BITS);

	typedef enum logic [1:0] {
		PH_SYNC  = 2'd0,
		PH_LEN   = 2'd1,
		PH_FRAME = 2'd2
	} phase_t;

	typedef struct packed {
		logic             wr_en;
		logic [IDX_W-1:0] wr_idx;
		logic [7:0]       wr_data;
		logic             start;
	} unp_ctl_t;

endpackage

// File: rtl/core/rc_link_frame_parser.sv
// rc_link_frame_parser: top level; sync/length/frame sequencing of received bytes.
// Depends on rclp_pkg, rclp_crc8 and rclp_unpack.
//
//   channel | handshake            | payload
//   --------+----------------------+----------------------------------------------
//   in      | in_valid, in_stall   | rx_byte[7:0]
//   out     | out_valid, out_stall | channel_index[3:0], channel_value[10:0],
//           |                      | last_channel
//
// Sync and length bytes, and the last byte of a frame, are accepted without a CRC stall.
// Type and payload bytes feed the bit-serial CRC: in_stall stays high as each is shifted.
// A good channel frame unpacks by a one-bit rotation of the 176-bit channel buffer,
// one transaction per 11-bit channel; in_stall stays high until channel 15 is taken.
// out_stall freezes the rotation at the next finished channel. Reset clears the buffer.
`timescale 1ns / 1ps

module rc_link_frame_parser (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  rx_byte,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [3:0]  channel_index,
	output logic [10:0] channel_value,
	output logic        last_channel
);

	localparam int CW = rclp_pkg::CNT_W;

	rclp_pkg::phase_t           ph_q;
	rclp_pkg::phase_t           ph_d;
	logic [CW-1:0]              bc_q;
	logic [CW-1:0]              bc_d;
	logic [CW-1:0]              flen_q;
	logic [CW-1:0]              flen_d;
	logic [7:0]                 type_q;
	logic                       type_we;
	logic [7:0]                 flen8;
	logic [CW-1:0]              bc_inc;
	logic [rclp_pkg::IDX_W-1:0] idx_full;
	logic                       acc;
	logic                       crc_clr;
	logic                       crc_load;
	logic [7:0]                 crc;
	logic                       crc_busy;
	logic                       unp_busy;
	rclp_pkg::unp_ctl_t         ctl;

	assign acc      = in_valid && !in_stall;
	assign in_stall = crc_busy || unp_busy;
	assign flen8    = rx_byte + 8'd2;
	assign bc_inc   = bc_q + CW'(1);
	assign idx_full = rclp_pkg::IDX_W'(bc_q - CW'(rclp_pkg::CH_FIRST));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q <= rclp_pkg::PH_SYNC;
		end else begin
			ph_q <= ph_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bc_q   <= '0;
			flen_q <= '0;
		end else begin
			bc_q   <= bc_d;
			flen_q <= flen_d;
		end
	end

	always_ff @(posedge clk) begin
		if (type_we) begin
			type_q <= rx_byte;
		end
	end

	always_comb begin
		ph_d        = ph_q;
		bc_d        = bc_q;
		flen_d      = flen_q;
		type_we     = 1'b0;
		crc_clr     = 1'b0;
		crc_load    = 1'b0;
		ctl.wr_en   = 1'b0;
		ctl.wr_idx  = idx_full;
		ctl.wr_data = rx_byte;
		ctl.start   = 1'b0;
		if (acc) begin
			case (ph_q)
				rclp_pkg::PH_LEN: begin
					if (flen8 < 8'(rclp_pkg::MIN_FRAME) ||
					    rclp_pkg::LEN_CMP_W'(flen8) >
					    rclp_pkg::LEN_CMP_W'(rclp_pkg::MAX_FRAME_BYTES)) begin
						ph_d = rclp_pkg::PH_SYNC;
					end else begin
						bc_d    = CW'(2);
						flen_d  = CW'(flen8);
						crc_clr = 1'b1;
						ph_d    = rclp_pkg::PH_FRAME;
					end
				end
				rclp_pkg::PH_FRAME: begin
					type_we   = (bc_q == CW'(2));
					ctl.wr_en = bc_q inside {[CW'(rclp_pkg::CH_FIRST):CW'(rclp_pkg::CH_LAST)]};
					if (bc_inc < flen_q) begin
						crc_load = 1'b1;
						bc_d     = bc_inc;
					end else begin
						ph_d      = rclp_pkg::PH_SYNC;
						bc_d      = '0;
						ctl.start = (crc == rx_byte) && (type_q == rclp_pkg::TYPE_CHANNELS);
					end
				end
				default: begin
					ph_d = rclp_pkg::PH_SYNC;
					if (rx_byte == rclp_pkg::SYNC_BYTE) begin
						bc_d = CW'(1);
						ph_d = rclp_pkg::PH_LEN;
					end
				end
			endcase
		end
	end

	rclp_crc8 u_crc (
		.clk    (clk),
		.arst_n (arst_n),
		.clr    (crc_clr),
		.load   (crc_load),
		.din    (rx_byte),
		.crc    (crc),
		.busy   (crc_busy)
	);

	rclp_unpack u_unpack (
		.clk           (clk),
		.arst_n        (arst_n),
		.ctl           (ctl),
		.busy          (unp_busy),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.channel_index (channel_index),
		.channel_value (channel_value),
		.last_channel  (last_channel)
	);

	a_no_rx_during_burst: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> in_stall)
		else $error("input accepted while channels are pending");

	a_burst_after_frame: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (ph_q == rclp_pkg::PH_SYNC))
		else $error("channel burst outside sync hunt");

	a_index_advance: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_stall && !last_channel) |=>
		(!out_valid || channel_index == $past(channel_index) + 4'd1))
		else $error("channel index skipped");

	a_crc_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		!(crc_busy && unp_busy))
		else $error("crc and unpack busy together");

endmodule

// File: rtl/core/rclp_crc8.sv
// rclp_crc8: bit-serial CRC-8 (polynomial 0xD5), one data bit per cycle, MSB first.
// Depends on rclp_pkg.
`timescale 1ns / 1ps

module rclp_crc8 (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       clr,
	input  logic       load,
	input  logic [7:0] din,
	output logic [7:0] crc,
	output logic       busy
);

	logic [7:0] sh_q;
	logic [7:0] crc_q;
	logic [2:0] cnt_q;
	logic       busy_q;
	logic       fb;

	assign fb   = crc_q[7] ^ sh_q[7];
	assign crc  = crc_q;
	assign busy = busy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_q  <= '0;
			cnt_q  <= '0;
			busy_q <= 1'b0;
		end else if (clr) begin
			crc_q  <= '0;
			busy_q <= 1'b0;
		end else if (load) begin
			cnt_q  <= '0;
			busy_q <= 1'b1;
		end else if (busy_q) begin
			crc_q <= {crc_q[6:0], 1'b0} ^ (fb ? rclp_pkg::CRC_POLY : 8'h00);
			cnt_q <= cnt_q + 3'd1;
			if (cnt_q == 3'd7) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			sh_q <= din;
		end else if (busy_q) begin
			sh_q <= {sh_q[6:0], 1'b0};
		end
	end

endmodule

// File: rtl/core/rclp_unpack.sv
// rclp_unpack: holds the frame's channel bytes and rotates them out one bit per cycle
// when out_stall allows, into 11-bit channel transactions. Depends on rclp_pkg.
`timescale 1ns / 1ps

module rclp_unpack (
	input  logic                           clk,
	input  logic                           arst_n,
	input  rclp_pkg::unp_ctl_t             ctl,
	output logic                           busy,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic [rclp_pkg::CHI_W-1:0]     channel_index,
	output logic [rclp_pkg::CHAN_BITS-1:0] channel_value,
	output logic                           last_channel
);

	localparam int TOT = rclp_pkg::CH_TOTAL;
	localparam int CB  = rclp_pkg::CHAN_BITS;

	logic [TOT-1:0]                   chan_q;
	logic [CB-1:0]                    ch_sh_q;
	logic [rclp_pkg::BITC_W-1:0]      bit_cnt_q;
	logic [rclp_pkg::CHI_W-1:0]       ch_idx_q;
	logic                             active_q;
	logic                             ov_q;
	logic [rclp_pkg::CHI_W-1:0]       oidx_q;
	logic [CB-1:0]                    oval_q;
	logic                             olast_q;
	logic [rclp_pkg::IDX_W+2:0]       wr_pos;
	logic                             chan_done;
	logic                             hold;
	logic                             step;
	logic                             emit;

	assign wr_pos    = {ctl.wr_idx, 3'b000};
	assign chan_done = (bit_cnt_q == rclp_pkg::BITC_W'(CB - 1));
	assign hold      = chan_done && ov_q && out_stall;
	assign step      = active_q && !hold;
	assign emit      = step && chan_done;

	assign busy          = active_q || ov_q;
	assign out_valid     = ov_q;
	assign channel_index = oidx_q;
	assign channel_value = oval_q;
	assign last_channel  = olast_q;

	// buffer contents survive across frames; reset clears them
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chan_q <= '0;
		end else if (ctl.wr_en) begin
			chan_q[wr_pos +: 8] <= ctl.wr_data;
		end else if (step) begin
			chan_q <= {chan_q[0], chan_q[TOT-1:1]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q  <= 1'b0;
			bit_cnt_q <= '0;
			ch_idx_q  <= '0;
			ov_q      <= 1'b0;
		end else begin
			if (ctl.start) begin
				active_q  <= 1'b1;
				bit_cnt_q <= '0;
				ch_idx_q  <= '0;
			end else if (step) begin
				if (chan_done) begin
					bit_cnt_q <= '0;
					ch_idx_q  <= ch_idx_q + rclp_pkg::CHI_W'(1);
					if (ch_idx_q == rclp_pkg::CHI_W'(rclp_pkg::NUM_CHANNELS - 1)) begin
						active_q <= 1'b0;
					end
				end else begin
					bit_cnt_q <= bit_cnt_q + rclp_pkg::BITC_W'(1);
				end
			end
			if (emit) begin
				ov_q <= 1'b1;
			end else if (ov_q && !out_stall) begin
				ov_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			ch_sh_q <= {chan_q[0], ch_sh_q[CB-1:1]};
		end
		if (emit) begin
			oidx_q  <= ch_idx_q;
			oval_q  <= {chan_q[0], ch_sh_q[CB-1:1]};
			olast_q <= (ch_idx_q == rclp_pkg::CHI_W'(rclp_pkg::NUM_CHANNELS - 1));
		end
	end

endmodule

// File: tb/sv/rc_link_frame_parser_tb.sv
// rc_link_frame_parser_tb: self-checking bench for the RC link frame parser.
// Sends directed and random byte streams, predicts channel output, checks it.
// Depends on rclp_pkg and rc_link_frame_parser.
`timescale 1ns / 1ps

module rc_link_frame_parser_tb;

	localparam int WATCHDOG_LIMIT = 2000;
	localparam int PHASE_BYTES    = 80;
	localparam int DRAIN_CYCLES   = 200;

	typedef enum logic [1:0] {
		CHK_PREDICT,
		CHK_NONE,
		CHK_FILL
	} row_check_t;

	typedef struct packed {
		int         lead;
		logic [7:0] len;
		logic [7:0] ftype;
		int         fill;
		logic       bad_crc;
		row_check_t how;
		logic [10:0] chval;
	} frame_row_t;

	typedef struct packed {
		logic [3:0]  idx;
		logic [10:0] val;
		logic        last;
	} chan_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [7:0]  rx_byte = 8'h00;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [3:0]  channel_index;
	logic [10:0] channel_value;
	logic        last_channel;

	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int mismatches = 0;
	int idle_cycles = 0;

	chan_t      chan_exp_q [$];
	logic [7:0] tx_bytes [$];

	rclp_pkg::phase_t rx_phase = rclp_pkg::PH_SYNC;
	int unsigned stored_cnt = 0;
	int unsigned frame_total = 0;
	logic [7:0]  frame_mem [rclp_pkg::MAX_FRAME_BYTES];
	logic [10:0] chan_vals [rclp_pkg::NUM_CHANNELS];

	frame_row_t dir_rows [9] = '{
		'{0,  8'hFF, rclp_pkg::TYPE_CHANNELS, 0,    1'b0, CHK_NONE,    11'd0},
		'{-1, 8'h01, rclp_pkg::TYPE_CHANNELS, 0,    1'b0, CHK_NONE,    11'd0},
		'{-1, 8'hC8, rclp_pkg::TYPE_CHANNELS, 0,    1'b0, CHK_NONE,    11'd0},
		'{-1, 8'h3F, rclp_pkg::TYPE_CHANNELS, 0,    1'b0, CHK_NONE,    11'd0},
		'{-1, 8'h02, rclp_pkg::TYPE_CHANNELS, 0,    1'b0, CHK_PREDICT, 11'd0},
		'{-1, 8'h03, 8'h42,                   255,  1'b0, CHK_NONE,    11'd0},
		'{-1, 8'h18, rclp_pkg::TYPE_CHANNELS, 255,  1'b0, CHK_FILL,    11'h7FF},
		'{-1, 8'h03, rclp_pkg::TYPE_CHANNELS, 0,    1'b1, CHK_NONE,    11'd0},
		'{-1, 8'h04, rclp_pkg::TYPE_CHANNELS, -1,   1'b0, CHK_PREDICT, 11'd0}
	};

	rc_link_frame_parser uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.rx_byte       (rx_byte),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.channel_index (channel_index),
		.channel_value (channel_value),
		.last_channel  (last_channel)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic logic [7:0] crc8_step(input logic [7:0] crc_in, input logic [7:0] d);
		logic [7:0] c;
		c = crc_in ^ d;
		for (int i = 0; i < 8; i++)
			c = c[7] ? ((c << 1) ^ rclp_pkg::CRC_POLY) : (c << 1);
		return c;
	endfunction

	// Advance the parser image by one byte; return the number of channels decoded.
	function automatic int decode_byte(input logic [7:0] b);
		logic [7:0]  flen8;
		logic [7:0]  crc;
		logic [23:0] w;
		int unsigned bitpos;
		int unsigned p;
		case (rx_phase)
		rclp_pkg::PH_LEN: begin
			flen8 = b + 8'd2;
			if (flen8 < rclp_pkg::MIN_FRAME || flen8 > rclp_pkg::MAX_FRAME_BYTES) begin
				rx_phase = rclp_pkg::PH_SYNC;
			end else begin
				frame_mem[1] = b;
				stored_cnt = 2;
				frame_total = flen8;
				rx_phase = rclp_pkg::PH_FRAME;
			end
			return 0;
		end
		rclp_pkg::PH_FRAME: begin
			frame_mem[stored_cnt] = b;
			stored_cnt++;
			if (stored_cnt < frame_total)
				return 0;
			rx_phase = rclp_pkg::PH_SYNC;
			stored_cnt = 0;
			crc = 8'h00;
			for (int i = 2; i <= frame_total - 2; i++)
				crc = crc8_step(crc, frame_mem[i]);
			if (crc != frame_mem[frame_total - 1] ||
			    frame_mem[2] != rclp_pkg::TYPE_CHANNELS)
				return 0;
			for (int n = 0; n < rclp_pkg::NUM_CHANNELS; n++) begin
				bitpos = n * rclp_pkg::CHAN_BITS;
				p = rclp_pkg::CH_FIRST + bitpos / 8;
				w = {frame_mem[p + 2], frame_mem[p + 1], frame_mem[p]};
				chan_vals[n] = 11'(w >> (bitpos % 8));
			end
			return rclp_pkg::NUM_CHANNELS;
		end
		default: begin
			rx_phase = rclp_pkg::PH_SYNC;
			if (b == rclp_pkg::SYNC_BYTE) begin
				frame_mem[0] = b;
				stored_cnt = 1;
				rx_phase = rclp_pkg::PH_LEN;
			end
		end
		endcase
		return 0;
	endfunction

	// Append a frame; fill < 0 gives random payload. Rejected lengths stop after the length byte.
	task automatic queue_frame(input logic [7:0] len, input logic [7:0] ftype, input int fill,
			input logic bad_crc);
		logic [7:0] flen8;
		logic [7:0] crc;
		logic [7:0] d;
		flen8 = len + 8'd2;
		tx_bytes.push_back(rclp_pkg::SYNC_BYTE);
		tx_bytes.push_back(len);
		if (flen8 < rclp_pkg::MIN_FRAME || flen8 > rclp_pkg::MAX_FRAME_BYTES)
			return;
		tx_bytes.push_back(ftype);
		crc = crc8_step(8'h00, ftype);
		for (int i = 0; i < flen8 - 4; i++) begin
			d = (fill < 0) ? 8'($urandom) : 8'(fill);
			tx_bytes.push_back(d);
			crc = crc8_step(crc, d);
		end
		if (bad_crc)
			crc ^= 8'($urandom_range(1, 255));
		tx_bytes.push_back(crc);
	endtask

	task automatic send_rx_byte(input logic [7:0] b, input row_check_t how,
			input logic [10:0] chval);
		int n;
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		rx_byte <= b;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		n = decode_byte(b);
		case (how)
		CHK_PREDICT: begin
			for (int i = 0; i < n; i++)
				chan_exp_q.push_back('{4'(i), chan_vals[i],
					i == rclp_pkg::NUM_CHANNELS - 1});
		end
		CHK_FILL: begin
			for (int i = 0; i < rclp_pkg::NUM_CHANNELS; i++)
				chan_exp_q.push_back('{4'(i), chval, i == rclp_pkg::NUM_CHANNELS - 1});
		end
		default: begin
		end
		endcase
	endtask

	task automatic drain_channels();
		in_valid <= 1'b0;
		do
			@(posedge clk);
		while (chan_exp_q.size() != 0);
	endtask

	always @(posedge clk) begin
		out_stall <= ($urandom_range(99) < recv_stall_pct);
	end

	always @(posedge clk) begin : chan_monitor
		chan_t exp_c;
		if (arst_n && out_valid && !out_stall) begin
			if (chan_exp_q.size() == 0) begin
				$display("%0t: unexpected channel transaction: idx %0d value %0d last %0d",
					$time, channel_index, channel_value, last_channel);
				mismatches++;
			end else begin
				exp_c = chan_exp_q.pop_front();
				if (channel_index !== exp_c.idx) begin
					$display("%0t: channel_index: expected %0d, got %0d",
						$time, exp_c.idx, channel_index);
					mismatches++;
				end
				if (channel_value !== exp_c.val) begin
					$display("%0t: channel_value (ch %0d): expected %0d, got %0d",
						$time, exp_c.idx, exp_c.val, channel_value);
					mismatches++;
				end
				if (last_channel !== exp_c.last) begin
					$display("%0t: last_channel (ch %0d): expected %0d, got %0d",
						$time, exp_c.idx, exp_c.last, last_channel);
					mismatches++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("rc_link_frame_parser regression: fail");
			$finish;
		end
	end

	initial begin : stimulus
		int send_pcts [4];
		int recv_pcts [4];
		int phase_bytes;
		int r;
		logic [7:0] len;
		logic [7:0] b;
		send_pcts = '{0, 68, 0, 26};
		recv_pcts = '{0, 0, 68, 26};
		for (int i = 0; i < rclp_pkg::MAX_FRAME_BYTES; i++)
			frame_mem[i] = 8'h00;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[k]) begin
			if (dir_rows[k].lead >= 0)
				tx_bytes.push_back(8'(dir_rows[k].lead));
			queue_frame(dir_rows[k].len, dir_rows[k].ftype, dir_rows[k].fill,
				dir_rows[k].bad_crc);
			while (tx_bytes.size() != 0) begin
				b = tx_bytes.pop_front();
				send_rx_byte(b, (tx_bytes.size() == 0 || dir_rows[k].how == CHK_PREDICT) ?
					dir_rows[k].how : CHK_NONE, dir_rows[k].chval);
			end
		end
		drain_channels();

		for (int ph = 0; ph < 4; ph++) begin
			send_idle_pct = send_pcts[ph];
			recv_stall_pct = recv_pcts[ph];
			phase_bytes = 0;
			while (phase_bytes < PHASE_BYTES) begin
				if ($urandom_range(99) < 8)
					repeat ($urandom_range(1, 3)) tx_bytes.push_back(8'($urandom));
				r = $urandom_range(99);
				if (r < 70)
					len = 8'd24;
				else if (r < 82)
					len = 8'($urandom_range(2, 23));
				else if (r < 90)
					len = ($urandom_range(1) != 0) ? 8'd62 : 8'($urandom_range(25, 62));
				else
					case ($urandom_range(3))
					0: len = 8'h00;
					1: len = 8'h01;
					2: len = 8'($urandom_range(254, 255));
					default: len = 8'($urandom_range(63, 253));
					endcase
				r = $urandom_range(99);
				queue_frame(len,
					($urandom_range(99) < 90) ? rclp_pkg::TYPE_CHANNELS : 8'($urandom),
					(r < 5) ? 255 : ((r < 10) ? 0 : -1),
					$urandom_range(99) < 12);
				while (tx_bytes.size() != 0) begin
					send_rx_byte(tx_bytes.pop_front(), CHK_PREDICT, 11'd0);
					phase_bytes++;
				end
			end
			drain_channels();
		end

		repeat (DRAIN_CYCLES) @(posedge clk);
		mismatches += chan_exp_q.size();
		if (mismatches == 0)
			$display("rc_link_frame_parser regression: pass");
		else
			$display("rc_link_frame_parser regression: fail");
		$finish;
	end

endmodule
